// File: hdl/tde_pkg.sv
// ---------------------------------------------------------------------------
// tde_pkg
// Shared types, constants and arithmetic helpers for the tilt encoder.
// ---------------------------------------------------------------------------
package tde_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int AVG_W        = 3;
    localparam int SCALE_W      = 4;
    localparam int ACC_W        = SAMPLE_WIDTH + 9;
    localparam int SC_W         = SAMPLE_WIDTH + 16;
    localparam int MIX_W        = SAMPLE_WIDTH + 1;
    localparam int MIX_LIMIT    = 255;

    localparam logic [7:0] TAG_RIGHT = 8'b0100_0000;
    localparam logic [7:0] TAG_LEFT  = 8'b1000_0000;
    localparam logic [7:0] TAG_DIR   = 8'b1100_0000;
    localparam logic [7:0] END_BYTE  = 8'd13;

    localparam logic [3:0] DIR_FWD   = 4'd1;
    localparam logic [3:0] DIR_RNEG  = 4'd2;
    localparam logic [3:0] DIR_LNEG  = 4'd4;
    localparam logic [3:0] DIR_BACK  = 4'd8;

    localparam logic REG_AVG   = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    localparam logic [1:0] BEAT_RIGHT = 2'd0;
    localparam logic [1:0] BEAT_LEFT  = 2'd1;
    localparam logic [1:0] BEAT_DIR   = 2'd2;
    localparam logic [1:0] BEAT_END   = 2'd3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [MIX_W-1:0]        mix_t;

    typedef struct packed {
        logic [AVG_W-1:0]   avg_shift;
        logic [SCALE_W-1:0] scale_shift;
    } cfg_t;

    typedef struct packed {
        logic [7:0] right_byte;
        logic [7:0] left_byte;
        logic [7:0] dir_byte;
    } msg_t;

    // (sample + (2^sh - 1) * old) / 2^sh, truncating toward zero
    function automatic sample_t smooth(sample_t sample, sample_t old, logic [AVG_W-1:0] sh);
        logic signed [ACC_W-1:0] sum;
        logic [ACC_W-1:0]        mask;
        logic signed [ACC_W-1:0] biased;
        sum    = ACC_W'(sample) + (ACC_W'(old) <<< sh) - ACC_W'(old);
        mask   = (ACC_W'(1) << sh) - ACC_W'(1);
        biased = sum + signed'(mask & {ACC_W{sum[ACC_W-1]}});
        return SAMPLE_WIDTH'(biased >>> sh);
    endfunction

    // v / 2^sh, truncating toward zero
    function automatic sample_t scale_down(sample_t v, logic [SCALE_W-1:0] sh);
        logic signed [SC_W-1:0] ext;
        logic [SC_W-1:0]        mask;
        logic signed [SC_W-1:0] biased;
        ext    = SC_W'(v);
        mask   = (SC_W'(1) << sh) - SC_W'(1);
        biased = ext + signed'(mask & {SC_W{ext[SC_W-1]}});
        return SAMPLE_WIDTH'(biased >>> sh);
    endfunction

    function automatic mix_t clamp_mix(mix_t v);
        mix_t res;
        if (v > MIX_W'(MIX_LIMIT))
            res = MIX_W'(MIX_LIMIT);
        else if (v < -MIX_W'(MIX_LIMIT))
            res = -MIX_W'(MIX_LIMIT);
        else
            res = v;
        return res;
    endfunction

    function automatic logic [7:0] magnitude(mix_t v);
        mix_t a;
        a = v[MIX_W-1] ? -v : v;
        return a[7:0];
    endfunction

endpackage

// File: hdl/tde_sample_if.sv
// ---------------------------------------------------------------------------
// tde_sample_if
// Valid/ready channel carrying one X/Y sample pair per beat.
// ---------------------------------------------------------------------------
interface tde_sample_if;
    logic              valid;
    logic              ready;
    tde_pkg::sample_t  sample_x;
    tde_pkg::sample_t  sample_y;

    modport source (output valid, output sample_x, output sample_y, input ready);
    modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

// File: hdl/tde_byte_if.sv
// ---------------------------------------------------------------------------
// tde_byte_if
// Valid/ready channel carrying one message byte per beat.
// ---------------------------------------------------------------------------
interface tde_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

// File: hdl/tde_cfg_regs.sv
// ---------------------------------------------------------------------------
// tde_cfg_regs
// APB register file holding the averaging and scale shifts.
// ---------------------------------------------------------------------------
module tde_cfg_regs
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output tde_pkg::cfg_t cfg
);

    tde_pkg::cfg_t cfg_reg;
    tde_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                tde_pkg::REG_AVG:   cfg_next.avg_shift   = pwdata[tde_pkg::AVG_W-1:0];
                tde_pkg::REG_SCALE: cfg_next.scale_shift = pwdata[tde_pkg::SCALE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_shift   <= tde_pkg::AVG_W'(3);
            cfg_reg.scale_shift <= tde_pkg::SCALE_W'(6);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            tde_pkg::REG_AVG:   prdata = 32'(cfg_reg.avg_shift);
            tde_pkg::REG_SCALE: prdata = 32'(cfg_reg.scale_shift);
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/tde_filter.sv
// ---------------------------------------------------------------------------
// tde_filter
// Input register, running averages and mixing into one three-byte message.
// ---------------------------------------------------------------------------
module tde_filter
(
    input  logic              clk,
    input  logic              rst_n,
    input  tde_pkg::cfg_t     cfg,
    tde_sample_if.sink        sample_ch,
    input  logic              msg_free,
    output logic              msg_load,
    output tde_pkg::msg_t     msg
);

    logic             in_valid_reg;
    logic             in_valid_next;
    tde_pkg::sample_t x_reg;
    tde_pkg::sample_t y_reg;
    tde_pkg::sample_t filt_x_reg;
    tde_pkg::sample_t filt_y_reg;
    tde_pkg::sample_t filt_x_next;
    tde_pkg::sample_t filt_y_next;
    tde_pkg::sample_t ax;
    tde_pkg::sample_t ay;
    tde_pkg::mix_t    right_mix;
    tde_pkg::mix_t    left_mix;
    logic [7:0]       right_mag;
    logic [7:0]       left_mag;
    logic [3:0]       dir;
    logic             in_take;

    assign msg_load        = in_valid_reg && msg_free;
    assign sample_ch.ready = !in_valid_reg || msg_free;
    assign in_take         = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (msg_load)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        filt_x_next = tde_pkg::smooth(x_reg, filt_x_reg, cfg.avg_shift);
        filt_y_next = tde_pkg::smooth(y_reg, filt_y_reg, cfg.avg_shift);
        ax          = tde_pkg::scale_down(filt_x_next, cfg.scale_shift);
        ay          = tde_pkg::scale_down(filt_y_next, cfg.scale_shift);
        right_mix   = tde_pkg::clamp_mix(tde_pkg::MIX_W'(ax) + tde_pkg::MIX_W'(ay));
        left_mix    = tde_pkg::clamp_mix(tde_pkg::MIX_W'(ax) - tde_pkg::MIX_W'(ay));
        right_mag   = tde_pkg::magnitude(right_mix);
        left_mag    = tde_pkg::magnitude(left_mix);
        case ({right_mix[tde_pkg::MIX_W-1], left_mix[tde_pkg::MIX_W-1]})
            2'b00:   dir = tde_pkg::DIR_FWD;
            2'b01:   dir = tde_pkg::DIR_RNEG;
            2'b10:   dir = tde_pkg::DIR_LNEG;
            default: dir = tde_pkg::DIR_BACK;
        endcase
        msg.right_byte = tde_pkg::TAG_RIGHT | {2'b00, right_mag[7:2]};
        msg.left_byte  = tde_pkg::TAG_LEFT  | {2'b00, left_mag[7:2]};
        msg.dir_byte   = tde_pkg::TAG_DIR   | {4'b0000, dir};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            filt_x_reg   <= '0;
            filt_y_reg   <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (msg_load)
            begin
                filt_x_reg <= filt_x_next;
                filt_y_reg <= filt_y_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            x_reg <= sample_ch.sample_x;
            y_reg <= sample_ch.sample_y;
        end
    end

endmodule

// File: hdl/tde_serializer.sv
// ---------------------------------------------------------------------------
// tde_serializer
// Message register and four-beat byte sequencer.
// ---------------------------------------------------------------------------
module tde_serializer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          msg_load,
    input  tde_pkg::msg_t msg,
    output logic          msg_free,
    tde_byte_if.source    byte_ch
);

    tde_pkg::msg_t msg_reg;
    logic          msg_valid_reg;
    logic          msg_valid_next;
    logic [1:0]    beat_cnt_reg;
    logic [1:0]    beat_cnt_next;
    logic          beat_take;
    logic          last_take;

    assign beat_take = byte_ch.valid && byte_ch.ready;
    assign last_take = beat_take && (beat_cnt_reg == tde_pkg::BEAT_END);
    assign msg_free  = !msg_valid_reg || last_take;

    always_comb
    begin
        msg_valid_next = msg_valid_reg;
        beat_cnt_next  = beat_cnt_reg;
        if (beat_take)
            beat_cnt_next = beat_cnt_reg + 2'd1;
        if (msg_load)
            msg_valid_next = 1'b1;
        else if (last_take)
            msg_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid_reg <= 1'b0;
            beat_cnt_reg  <= tde_pkg::BEAT_RIGHT;
        end
        else
        begin
            msg_valid_reg <= msg_valid_next;
            beat_cnt_reg  <= beat_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_load)
            msg_reg <= msg;
    end

    always_comb
    begin
        case (beat_cnt_reg)
            tde_pkg::BEAT_RIGHT: byte_ch.out_byte = msg_reg.right_byte;
            tde_pkg::BEAT_LEFT:  byte_ch.out_byte = msg_reg.left_byte;
            tde_pkg::BEAT_DIR:   byte_ch.out_byte = msg_reg.dir_byte;
            default:             byte_ch.out_byte = tde_pkg::END_BYTE;
        endcase
    end

    assign byte_ch.valid     = msg_valid_reg;
    assign byte_ch.last_byte = (beat_cnt_reg == tde_pkg::BEAT_END);

endmodule

// File: hdl/tilt_to_differential_drive_encoder.sv
// ---------------------------------------------------------------------------
// tilt_to_differential_drive_encoder
// Smooths X/Y tilt samples and encodes them as a four-byte drive message.
// ---------------------------------------------------------------------------
// A sample beat goes into the input register, then into the message register
// once the four-beat byte sequencer is free, and its first byte is offered.
// A new sample is held in the input register while a message is being sent.
// Reset: averages cleared to zero, avg_shift 3, scale_shift 6, channels empty.
module tilt_to_differential_drive_encoder
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    tde_sample_if.sink   sample_ch,
    tde_byte_if.source   byte_ch
);

    tde_pkg::cfg_t cfg;
    tde_pkg::msg_t msg;
    logic          msg_load;
    logic          msg_free;

    tde_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tde_filter u_filter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample_ch (sample_ch),
        .msg_free  (msg_free),
        .msg_load  (msg_load),
        .msg       (msg)
    );

    tde_serializer u_ser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .msg_load (msg_load),
        .msg      (msg),
        .msg_free (msg_free),
        .byte_ch  (byte_ch)
    );

    a_load_starts_msg: assert property (@(posedge clk) disable iff (!rst_n)
        msg_load |=> byte_ch.valid && !byte_ch.last_byte
                     && byte_ch.out_byte[7:6] == 2'b01)
        else $error("message load did not present a right byte");

    a_msg_continues: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ch.valid && byte_ch.ready && !byte_ch.last_byte |=> byte_ch.valid)
        else $error("message broken before its last beat");

    a_last_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
        byte_ch.valid && byte_ch.last_byte |-> byte_ch.out_byte == tde_pkg::END_BYTE)
        else $error("closing beat is not a carriage return");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        msg_load |-> !byte_ch.valid || (byte_ch.ready && byte_ch.last_byte))
        else $error("message register overwritten");

endmodule

// File: tb/tilt_to_differential_drive_encoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tilt_to_differential_drive_encoder_tb
// Drives X/Y sample pairs through the encoder under several filter and scale
// settings and checks every message byte against a behavioural predictor of
// the averaging, scaling, mixing and direction encoding.
// ---------------------------------------------------------------------------
module tilt_to_differential_drive_encoder_tb;

    localparam int          CHOKE_AT     = 120;
    localparam int          CHOKE_CYCLES = 80;
    localparam int          STALL_LIMIT  = 1000;
    localparam logic [2:0]  ADDR_AVG     = {tde_pkg::REG_AVG, 2'b00};
    localparam logic [2:0]  ADDR_SCALE   = {tde_pkg::REG_SCALE, 2'b00};

    typedef struct packed {
        tde_pkg::sample_t x;
        tde_pkg::sample_t y;
    } tilt_pair_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } drive_byte_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tde_sample_if sample_ch ();
    tde_byte_if   byte_ch ();

    tilt_to_differential_drive_encoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample_ch (sample_ch),
        .byte_ch   (byte_ch)
    );

    tilt_pair_t  tilt_queue[$];
    drive_byte_t drive_bytes_due[$];

    logic [2:0]  avg_cfg;
    logic [3:0]  scale_cfg;
    longint      avg_x;
    longint      avg_y;

    int          error_count;
    int          samples_taken;
    int          bytes_seen;
    int          choke_left;
    bit          choke_done;
    int          idle_cycles;

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR %0t ns: %s: got %02h, expected %02h", $realtime, what, got, want);
        error_count++;
    endtask

    // exponential average, scale, mix, saturate, then the four-byte message
    task automatic encode_tilt(input tde_pkg::sample_t sx, input tde_pkg::sample_t sy);
        longint     wdiv;
        longint     sdiv;
        longint     ax;
        longint     ay;
        longint     right;
        longint     left;
        longint     rmag;
        longint     lmag;
        logic [3:0] heading;
        wdiv  = longint'(1) << avg_cfg;
        avg_x = (longint'(sx) + (wdiv - 1) * avg_x) / wdiv;
        avg_y = (longint'(sy) + (wdiv - 1) * avg_y) / wdiv;
        sdiv  = longint'(1) << scale_cfg;
        ax    = avg_x / sdiv;
        ay    = avg_y / sdiv;
        right = ax + ay;
        left  = ax - ay;
        if (right > tde_pkg::MIX_LIMIT)
            right = tde_pkg::MIX_LIMIT;
        else if (right < -tde_pkg::MIX_LIMIT)
            right = -tde_pkg::MIX_LIMIT;
        if (left > tde_pkg::MIX_LIMIT)
            left = tde_pkg::MIX_LIMIT;
        else if (left < -tde_pkg::MIX_LIMIT)
            left = -tde_pkg::MIX_LIMIT;
        if (right >= 0 && left >= 0)
            heading = tde_pkg::DIR_FWD;
        else if (right >= 0)
            heading = tde_pkg::DIR_RNEG;
        else if (left >= 0)
            heading = tde_pkg::DIR_LNEG;
        else
            heading = tde_pkg::DIR_BACK;
        rmag = (right < 0) ? -right : right;
        lmag = (left < 0) ? -left : left;
        drive_bytes_due.push_back('{tde_pkg::TAG_RIGHT | 8'(rmag >> 2), 1'b0});
        drive_bytes_due.push_back('{tde_pkg::TAG_LEFT | 8'(lmag >> 2), 1'b0});
        drive_bytes_due.push_back('{tde_pkg::TAG_DIR | 8'(heading), 1'b0});
        drive_bytes_due.push_back('{tde_pkg::END_BYTE, 1'b1});
    endtask

    // sample driver
    always @(posedge clk)
    begin
        tilt_pair_t pair;
        bit         go;
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                encode_tilt(sample_ch.sample_x, sample_ch.sample_y);
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                go = tilt_queue.size() > 0 &&
                     ((samples_taken >= 150 && samples_taken < 200) ||
                      $urandom_range(99) >= 29);
                if (go)
                begin
                    pair = tilt_queue.pop_front();
                    sample_ch.valid    <= 1'b1;
                    sample_ch.sample_x <= pair.x;
                    sample_ch.sample_y <= pair.y;
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // byte monitor
    always @(posedge clk)
    begin
        drive_byte_t want;
        if (!rst_n)
        begin
            byte_ch.ready <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                bytes_seen++;
                if (drive_bytes_due.size() == 0)
                begin
                    report_mismatch("byte beat with nothing due", byte_ch.out_byte, 8'h00);
                end
                else
                begin
                    want = drive_bytes_due.pop_front();
                    if (byte_ch.out_byte !== want.data)
                        report_mismatch("out_byte", byte_ch.out_byte, want.data);
                    if (byte_ch.last_byte !== want.last)
                        report_mismatch("last_byte", 8'(byte_ch.last_byte), 8'(want.last));
                end
            end
            if (choke_left > 0)
            begin
                choke_left--;
                byte_ch.ready <= 1'b0;
            end
            else if (!choke_done && bytes_seen >= CHOKE_AT)
            begin
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES - 1;
                byte_ch.ready <= 1'b0;
            end
            else
            begin
                byte_ch.ready <= (bytes_seen >= 600 && bytes_seen < 800) ||
                                 $urandom_range(99) >= 29;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (byte_ch.valid && byte_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_AVG)
            avg_cfg = data[2:0];
        else if (addr == ADDR_SCALE)
            scale_cfg = data[3:0];
    endtask

    task automatic set_drive_cfg(input int avg, input int scale);
        logic [31:0] spare;
        spare = $urandom_range(1) ? $urandom : 32'd0;
        reg_write(ADDR_AVG, (spare << 4) | 32'(avg));
        spare = $urandom_range(1) ? $urandom : 32'd0;
        reg_write(ADDR_SCALE, (spare << 4) | 32'(scale));
    endtask

    task automatic queue_pair(input int x, input int y);
        @(negedge clk);
        tilt_queue.push_back('{tde_pkg::sample_t'(x), tde_pkg::sample_t'(y)});
    endtask

    // wait for every message to come back, then let the pipeline settle
    task automatic drain_all();
        while (tilt_queue.size() != 0 || sample_ch.valid || drive_bytes_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic tde_pkg::sample_t pick_sample(input int scale);
        longint span;
        int     mode;
        mode = $urandom_range(9);
        if (mode < 2)
            return tde_pkg::sample_t'($urandom);
        if (mode == 2)
        begin
            case ($urandom_range(3))
                0: return tde_pkg::sample_t'(-32768);
                1: return tde_pkg::sample_t'(32767);
                2: return tde_pkg::sample_t'(0);
                default: return tde_pkg::sample_t'(-1);
            endcase
        end
        span = longint'(300) << scale;
        if (span > 32767)
            span = 32767;
        return tde_pkg::sample_t'(longint'($urandom_range(32'(2 * span))) - span);
    endfunction

    task automatic random_phase(input int avg, input int scale, input int count);
        tilt_pair_t held;
        held = '0;
        set_drive_cfg(avg, scale);
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            // runs of a held tilt let the average settle
            if (i == 0 || $urandom_range(2) != 0)
                held = '{pick_sample(scale), pick_sample(scale)};
            tilt_queue.push_back(held);
        end
        drain_all();
    endtask

    initial
    begin
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.sample_x = '0;
        sample_ch.sample_y = '0;
        byte_ch.ready      = 1'b0;
        avg_cfg            = 3'd3;
        scale_cfg          = 4'd6;
        avg_x              = 0;
        avg_y              = 0;
        error_count        = 0;
        samples_taken      = 0;
        bytes_seen         = 0;
        choke_left         = 0;
        choke_done         = 1'b0;
        idle_cycles        = 0;
        rst_n              = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings
        queue_pair(0, 0);
        queue_pair(32767, 32767);
        queue_pair(-32768, -32768);
        queue_pair(32767, -32768);
        queue_pair(-32768, 32767);
        queue_pair(-1, -1);
        drain_all();

        // no averaging, no scaling: saturation and all four headings
        set_drive_cfg(0, 0);
        queue_pair(32767, 32767);
        queue_pair(100, -300);
        queue_pair(-300, 100);
        queue_pair(-300, -100);
        queue_pair(50, -50);
        queue_pair(-50, 50);
        queue_pair(3, -7);
        queue_pair(-1, 0);
        drain_all();

        // heaviest averaging, scale beyond the nominal range
        set_drive_cfg(7, 15);
        queue_pair(-32768, -32768);
        queue_pair(32767, 32767);
        queue_pair(12345, -23456);
        drain_all();

        set_drive_cfg(0, 10);
        queue_pair(-32768, 1023);
        queue_pair(-1024, 1024);
        queue_pair(1023, -1);
        drain_all();

        random_phase(7, 0, 40);
        random_phase(0, 10, 40);
        random_phase(1, 3, 40);
        random_phase(0, 0, 40);
        for (int p = 0; p < 3; p++)
            random_phase($urandom_range(7),
                         $urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(10), 40);

        drain_all();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
hdl/tde_pkg.sv
hdl/tde_sample_if.sv
hdl/tde_byte_if.sv
hdl/tde_cfg_regs.sv
hdl/tde_filter.sv
hdl/tde_serializer.sv
hdl/tilt_to_differential_drive_encoder.sv
tb/tilt_to_differential_drive_encoder_tb.sv
